[design/pid_position_controller_assert.svh]
// Assertion macros used by pid_position_controller, which checks itself.
`ifndef PID_POSITION_CONTROLLER_ASSERT_SVH
`define PID_POSITION_CONTROLLER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pidc_pkg.sv]
`default_nettype none

package pidc_pkg;

    localparam int unsigned DataW      = 32;
    localparam int unsigned MulW       = DataW + 1;
    localparam int unsigned ProdW      = 2 * MulW;
    localparam int unsigned IntegW     = 64;
    localparam int unsigned AccW       = 96;
    localparam int unsigned ITermShift = 24;
    localparam int unsigned PdShift    = 16;
    localparam int unsigned IClampBit  = 50;
    localparam int unsigned SumW       = 54;
    localparam int unsigned DivCntW    = $clog2(DataW + 1);
    localparam int unsigned InW        = 3 * DataW;
    localparam int unsigned OutW       = 2 * DataW;

    localparam int unsigned CfgAddrW = 2;
    localparam logic [CfgAddrW-1:0] CFG_KP = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_KI = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_KD = 2'd2;

    localparam logic [DataW-1:0] KP_RESET = 32'd65536;
    localparam logic [DataW-1:0] KI_RESET = 32'd17;
    localparam logic [DataW-1:0] KD_RESET = 32'd65536000;

    localparam logic [DataW-1:0] S32_MAX = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] S32_MIN = {1'b1, {(DataW-1){1'b0}}};

    // Datapath operations.
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_ERR      = 4'd1;
    localparam t_op OP_DIV_INIT = 4'd2;
    localparam t_op OP_ADD_P    = 4'd3;
    localparam t_op OP_INTEG    = 4'd4;
    localparam t_op OP_ACC_LO   = 4'd5;
    localparam t_op OP_ACC_HI   = 4'd6;
    localparam t_op OP_ADD_I    = 4'd7;
    localparam t_op OP_DIV_STEP = 4'd8;
    localparam t_op OP_ADD_D    = 4'd9;
    localparam t_op OP_FINISH   = 4'd10;
    localparam t_op OP_FIRST    = 4'd11;

    // Multiplier operand selection.
    typedef logic [2:0] t_mul;
    localparam t_mul MUL_NONE  = 3'd0;
    localparam t_mul MUL_KP_E  = 3'd1;
    localparam t_mul MUL_E_DT  = 3'd2;
    localparam t_mul MUL_KI_LO = 3'd3;
    localparam t_mul MUL_KI_HI = 3'd4;
    localparam t_mul MUL_KD_Q  = 3'd5;

    // Jump conditions.
    typedef logic [1:0] t_cond;
    localparam t_cond COND_NEVER    = 2'd0;
    localparam t_cond COND_NO_STAMP = 2'd1;
    localparam t_cond COND_DT_ZERO  = 2'd2;
    localparam t_cond COND_DIV_MORE = 2'd3;

    // End-of-program marks.
    typedef logic [1:0] t_fin;
    localparam t_fin FIN_NONE   = 2'd0;
    localparam t_fin FIN_RESULT = 2'd1;
    localparam t_fin FIN_EMPTY  = 2'd2;

    localparam int unsigned StepW = 4;
    typedef logic [StepW-1:0] t_step;
    localparam t_step ST_ERR      = 4'd0;
    localparam t_step ST_MUL_P    = 4'd1;
    localparam t_step ST_MUL_EDT  = 4'd2;
    localparam t_step ST_INTEG    = 4'd3;
    localparam t_step ST_MUL_ILO  = 4'd4;
    localparam t_step ST_MUL_IHI  = 4'd5;
    localparam t_step ST_ACC_HI   = 4'd6;
    localparam t_step ST_ADD_I    = 4'd7;
    localparam t_step ST_DIV      = 4'd8;
    localparam t_step ST_MUL_D    = 4'd9;
    localparam t_step ST_ADD_D    = 4'd10;
    localparam t_step ST_FINISH   = 4'd11;
    localparam t_step ST_FIRST    = 4'd12;

    typedef struct packed {
        t_op   op;
        t_mul  mul;
        t_cond cond;
        t_step target;
        t_fin  fin;
    } t_uword;

    typedef struct packed {
        logic exec;
        t_op  op;
        t_mul mul;
    } t_ctl;

    typedef struct packed {
        logic no_stamp;
        logic dt_zero;
        logic div_more;
    } t_flags;

    function automatic t_uword uw(input t_op op, input t_mul mul, input t_cond cond,
                                  input t_step target, input t_fin fin);
        t_uword w;
        w.op     = op;
        w.mul    = mul;
        w.cond   = cond;
        w.target = target;
        w.fin    = fin;
        return w;
    endfunction

    // Control program. A step whose condition holds jumps to its target,
    // otherwise it falls through to the next step; a step with an end mark ends the program.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            ST_ERR:     w = uw(OP_ERR,      MUL_NONE,  COND_NO_STAMP, ST_FIRST,  FIN_NONE);
            ST_MUL_P:   w = uw(OP_DIV_INIT, MUL_KP_E,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_MUL_EDT: w = uw(OP_ADD_P,    MUL_E_DT,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_INTEG:   w = uw(OP_INTEG,    MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_MUL_ILO: w = uw(OP_NOP,      MUL_KI_LO, COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_MUL_IHI: w = uw(OP_ACC_LO,   MUL_KI_HI, COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_ACC_HI:  w = uw(OP_ACC_HI,   MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_ADD_I:   w = uw(OP_ADD_I,    MUL_NONE,  COND_DT_ZERO,  ST_FINISH, FIN_NONE);
            ST_DIV:     w = uw(OP_DIV_STEP, MUL_NONE,  COND_DIV_MORE, ST_DIV,    FIN_NONE);
            ST_MUL_D:   w = uw(OP_NOP,      MUL_KD_Q,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_ADD_D:   w = uw(OP_ADD_D,    MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_NONE);
            ST_FINISH:  w = uw(OP_FINISH,   MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_RESULT);
            ST_FIRST:   w = uw(OP_FIRST,    MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_EMPTY);
            default:    w = uw(OP_NOP,      MUL_NONE,  COND_NEVER,    ST_ERR,    FIN_EMPTY);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/pidc_seq.sv]
`default_nettype none

module pidc_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_hold,
    input  wire pidc_pkg::t_flags i_flags,
    output pidc_pkg::t_ctl       o_ctl,
    output logic                 o_busy
);

    logic             r_busy;
    logic             n_busy;
    pidc_pkg::t_step  r_step;
    pidc_pkg::t_step  n_step;
    pidc_pkg::t_uword uword;
    logic             cond_true;
    logic             stall;

    always_comb begin
        uword = pidc_pkg::ucode_rom(r_step);
        unique case (uword.cond)
            pidc_pkg::COND_NO_STAMP: cond_true = i_flags.no_stamp;
            pidc_pkg::COND_DT_ZERO:  cond_true = i_flags.dt_zero;
            pidc_pkg::COND_DIV_MORE: cond_true = i_flags.div_more;
            default:                 cond_true = 1'b0;
        endcase
        // The last step waits while the previous word is still in the output register.
        stall = (uword.fin == pidc_pkg::FIN_RESULT) && i_hold;

        o_ctl.exec = r_busy && !stall;
        o_ctl.op   = uword.op;
        o_ctl.mul  = uword.mul;

        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = pidc_pkg::ST_ERR;
            end
        end else if (stall) begin
            n_step = r_step;
        end else if (uword.fin != pidc_pkg::FIN_NONE) begin
            n_busy = 1'b0;
        end else if (cond_true) begin
            n_step = uword.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= pidc_pkg::ST_ERR;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

[design/pidc_dpath.sv]
`default_nettype none

module pidc_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [pidc_pkg::InW-1:0]      i_item,
    input  wire logic [pidc_pkg::DataW-1:0]    i_kp,
    input  wire logic [pidc_pkg::DataW-1:0]    i_ki,
    input  wire logic [pidc_pkg::DataW-1:0]    i_kd,
    input  wire pidc_pkg::t_ctl                i_ctl,
    output pidc_pkg::t_flags                   o_flags,
    output logic [pidc_pkg::DataW-1:0]         o_drive,
    output logic [pidc_pkg::DataW-1:0]         o_error
);

    localparam int unsigned W = pidc_pkg::DataW;
    localparam logic signed [pidc_pkg::AccW-1:0] IMax =
        {{(pidc_pkg::AccW-pidc_pkg::IClampBit-1){1'b0}}, 1'b1, {pidc_pkg::IClampBit{1'b0}}};
    localparam logic signed [pidc_pkg::AccW-1:0] IMin = -IMax;
    localparam logic signed [pidc_pkg::SumW-1:0] SumMax =
        {{(pidc_pkg::SumW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [pidc_pkg::SumW-1:0] SumMin =
        {{(pidc_pkg::SumW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Item and per-item work registers.
    logic [W-1:0] r_tgt;
    logic [W-1:0] r_meas;
    logic [W-1:0] r_stamp;
    logic [W-1:0] r_e;
    logic [W-1:0] r_dt;
    logic signed [pidc_pkg::ProdW-1:0] r_prod;
    logic signed [pidc_pkg::AccW-1:0]  r_acc;
    logic signed [pidc_pkg::SumW-1:0]  r_sum;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_quo;
    logic         r_neg;
    logic [pidc_pkg::DivCntW-1:0] r_cnt;

    // Controller state kept across items.
    logic signed [pidc_pkg::IntegW-1:0] r_integ;
    logic [W-1:0] r_prev;
    logic [W-1:0] r_last;
    logic         r_have;

    logic [W:0]   diff;
    logic [W-1:0] e_sat;
    logic [W:0]   num;
    logic [W:0]   mag;
    logic [W:0]   rem_sh;
    logic         rem_ge;
    logic signed [pidc_pkg::ProdW-1:0]  prod_sh;
    logic signed [pidc_pkg::AccW-1:0]   i_sh;
    logic signed [pidc_pkg::AccW-1:0]   i_clamped;
    logic [pidc_pkg::IntegW:0]          integ_sum;
    logic [pidc_pkg::IntegW-1:0]        integ_sat;
    logic [W:0]   q_s;
    logic signed [pidc_pkg::MulW-1:0]   mul_a;
    logic signed [pidc_pkg::MulW-1:0]   mul_b;
    logic signed [pidc_pkg::ProdW-1:0]  mul_p;

    always_comb begin
        diff = {r_tgt[W-1], r_tgt} - {r_meas[W-1], r_meas};
        if (diff[W] != diff[W-1]) begin
            e_sat = diff[W] ? pidc_pkg::S32_MIN : pidc_pkg::S32_MAX;
        end else begin
            e_sat = diff[W-1:0];
        end

        num = {r_e[W-1], r_e} - {r_prev[W-1], r_prev};
        mag = num[W] ? (~num + 1'b1) : num;

        // One restoring step of the magnitude divide.
        rem_sh = {r_rem, r_quo[W-1]};
        rem_ge = rem_sh >= {1'b0, r_dt};

        prod_sh   = r_prod >>> pidc_pkg::PdShift;
        i_sh      = r_acc >>> pidc_pkg::ITermShift;
        if (i_sh > IMax) begin
            i_clamped = IMax;
        end else if (i_sh < IMin) begin
            i_clamped = IMin;
        end else begin
            i_clamped = i_sh;
        end

        integ_sum = {r_integ[pidc_pkg::IntegW-1], r_integ}
                  + {r_prod[pidc_pkg::IntegW-1], r_prod[pidc_pkg::IntegW-1:0]};
        if (integ_sum[pidc_pkg::IntegW] != integ_sum[pidc_pkg::IntegW-1]) begin
            integ_sat = integ_sum[pidc_pkg::IntegW]
                      ? {1'b1, {(pidc_pkg::IntegW-1){1'b0}}}
                      : {1'b0, {(pidc_pkg::IntegW-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[pidc_pkg::IntegW-1:0];
        end

        q_s = r_neg ? (~{1'b0, r_quo} + 1'b1) : {1'b0, r_quo};

        unique case (i_ctl.mul)
            pidc_pkg::MUL_KP_E: begin
                mul_a = {i_kp[W-1], i_kp};
                mul_b = {r_e[W-1], r_e};
            end
            pidc_pkg::MUL_E_DT: begin
                mul_a = {r_e[W-1], r_e};
                mul_b = {1'b0, r_dt};
            end
            pidc_pkg::MUL_KI_LO: begin
                mul_a = {i_ki[W-1], i_ki};
                mul_b = {1'b0, r_integ[W-1:0]};
            end
            pidc_pkg::MUL_KI_HI: begin
                mul_a = {i_ki[W-1], i_ki};
                mul_b = {r_integ[pidc_pkg::IntegW-1], r_integ[pidc_pkg::IntegW-1:W]};
            end
            pidc_pkg::MUL_KD_Q: begin
                mul_a = {i_kd[W-1], i_kd};
                mul_b = q_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        if (r_sum > SumMax) begin
            o_drive = pidc_pkg::S32_MAX;
        end else if (r_sum < SumMin) begin
            o_drive = pidc_pkg::S32_MIN;
        end else begin
            o_drive = r_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tgt   <= i_item[W-1:0];
            r_meas  <= i_item[2*W-1:W];
            r_stamp <= i_item[3*W-1:2*W];
        end
        if (i_ctl.exec && (i_ctl.mul != pidc_pkg::MUL_NONE)) begin
            r_prod <= mul_p;
        end
        if (i_ctl.exec) begin
            unique case (i_ctl.op)
                pidc_pkg::OP_ERR: begin
                    r_e  <= e_sat;
                    r_dt <= r_stamp - r_last;
                end
                pidc_pkg::OP_DIV_INIT: begin
                    r_neg <= num[W];
                    r_quo <= mag[W-1:0];
                    r_rem <= '0;
                    r_cnt <= pidc_pkg::DivCntW'(W);
                end
                pidc_pkg::OP_ADD_P: begin
                    r_sum <= prod_sh[pidc_pkg::SumW-1:0];
                end
                pidc_pkg::OP_ACC_LO: begin
                    r_acc <= {{(pidc_pkg::AccW-pidc_pkg::ProdW){r_prod[pidc_pkg::ProdW-1]}},
                              r_prod};
                end
                pidc_pkg::OP_ACC_HI: begin
                    r_acc <= r_acc + {r_prod[pidc_pkg::IntegW-1:0], {W{1'b0}}};
                end
                pidc_pkg::OP_ADD_I: begin
                    r_sum <= r_sum + i_clamped[pidc_pkg::SumW-1:0];
                end
                pidc_pkg::OP_DIV_STEP: begin
                    r_rem <= rem_ge ? (rem_sh[W-1:0] - r_dt) : rem_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], rem_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                pidc_pkg::OP_ADD_D: begin
                    r_sum <= r_sum + prod_sh[pidc_pkg::SumW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
            r_last  <= '0;
            r_have  <= 1'b0;
        end else if (i_ctl.exec) begin
            unique case (i_ctl.op)
                pidc_pkg::OP_INTEG: begin
                    r_integ <= integ_sat;
                end
                pidc_pkg::OP_FINISH: begin
                    r_prev <= r_e;
                    r_last <= r_stamp;
                end
                pidc_pkg::OP_FIRST: begin
                    r_last <= r_stamp;
                    r_have <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_flags.no_stamp = !r_have;
    assign o_flags.dt_zero  = (r_dt == '0);
    assign o_flags.div_more = (r_cnt != pidc_pkg::DivCntW'(1));
    assign o_error          = r_e;

endmodule

`default_nettype wire

[design/pid_position_controller.sv]
// Each input word yields a result word, but the first word after reset gives no result;
// when dt is zero the derivative term is skipped. A new word is taken only when idle,
// so the block is through with one word before it takes the next; the bit-serial divide
// of the derivative term and the single shared 33x33 multiplier set the pace of a word.
// Reset (synchronous, active low) clears the integral, previous error, stored stamp and
// the output valid flag, and loads the gains with their default values.
`default_nettype none

`include "pid_position_controller_assert.svh"

module pid_position_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: target_position [31:0], measured_position [63:32], time_stamp [95:64]
    input  wire logic [pidc_pkg::InW-1:0]         i_s_tdata,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: drive_value [31:0], error_value [63:32]
    output logic [pidc_pkg::OutW-1:0]             o_m_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pidc_pkg::CfgAddrW-1:0]    i_cfg_addr,
    input  wire logic [pidc_pkg::DataW-1:0]       i_cfg_wdata
);

    logic [pidc_pkg::DataW-1:0] r_kp;
    logic [pidc_pkg::DataW-1:0] r_ki;
    logic [pidc_pkg::DataW-1:0] r_kd;
    logic                       r_out_valid;
    logic [pidc_pkg::DataW-1:0] r_drive;
    logic [pidc_pkg::DataW-1:0] r_err;

    logic                       seq_busy;
    logic                       s_accept;
    logic                       out_hold;
    logic                       w_result;
    pidc_pkg::t_ctl             ctl;
    pidc_pkg::t_flags           flags;
    logic [pidc_pkg::DataW-1:0] drive;
    logic [pidc_pkg::DataW-1:0] err;

    assign o_s_tready = !seq_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_hold   = r_out_valid && !i_m_tready;
    assign w_result   = ctl.exec && (ctl.op == pidc_pkg::OP_FINISH);

    pidc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_hold  (out_hold),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_busy  (seq_busy)
    );

    pidc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_accept),
        .i_item  (i_s_tdata),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .i_ctl   (ctl),
        .o_flags (flags),
        .o_drive (drive),
        .o_error (err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pidc_pkg::KP_RESET;
            r_ki <= pidc_pkg::KI_RESET;
            r_kd <= pidc_pkg::KD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pidc_pkg::CFG_KP: r_kp <= i_cfg_wdata;
                pidc_pkg::CFG_KI: r_ki <= i_cfg_wdata;
                pidc_pkg::CFG_KD: r_kd <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_drive <= drive;
            r_err   <= err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_err, r_drive};

    `PIDC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_result, !out_hold, "result overwrote a pending word")
    `PIDC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_accept, !o_s_tready, "sequencer did not start")
    `PIDC_ASSERT_NXT(a_idle_after_result, i_clk, i_rst_n, w_result, o_s_tready, "sequencer did not return idle")

endmodule

`default_nettype wire

[verif/pid_checker.sv]
module pid_checker
    import pidc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // tdata: target_position [31:0], measured_position [63:32], time_stamp [95:64]
    input  wire logic [InW-1:0]      i_s_tdata,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // tdata: drive_value [31:0], error_value [63:32]
    input  wire logic [OutW-1:0]     i_m_tdata,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [DataW-1:0]    i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_zero_dt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_LO = -64'sh0000_0000_8000_0000;
    localparam longint S64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_LO = 64'sh8000_0000_0000_0000;
    localparam longint ITERM_LIM = 64'sd1 << IClampBit;

    // Packed from the top down, so the error sits in the upper half as on the bus.
    typedef struct packed {
        logic signed [DataW-1:0] err;
        logic signed [DataW-1:0] drive;
    } t_pid_result;

    logic signed [DataW-1:0] kp_gain;
    logic signed [DataW-1:0] ki_gain;
    logic signed [DataW-1:0] kd_gain;

    longint         integ_acc;
    longint         prev_err;
    logic [DataW-1:0] prev_stamp;
    bit             stamp_seen;

    t_pid_result expected_drive_q[$];

    function automatic longint clamp32(input longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    function automatic longint add_sat64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_LO : S64_HI;
        return s;
    endfunction

    // ki * integral / 2^24 rounded toward minus infinity, limited to +-2^50.
    function automatic longint integral_drive(input logic signed [DataW-1:0] k,
                                              input longint s);
        logic signed [95:0] k_w;
        logic signed [95:0] s_w;
        logic signed [95:0] prod;
        logic signed [95:0] shifted;
        k_w = k;
        s_w = s;
        prod = k_w * s_w;
        shifted = prod >>> ITermShift;
        if (shifted > ITERM_LIM) return ITERM_LIM;
        if (shifted < -ITERM_LIM) return -ITERM_LIM;
        return longint'(shifted);
    endfunction

    // Advances the controller state by one sample; returns 0 when no word results.
    function automatic bit predict_drive(input logic [InW-1:0] word, output t_pid_result res);
        logic signed [DataW-1:0] tgt;
        logic signed [DataW-1:0] meas;
        logic [DataW-1:0]        stamp;
        logic [DataW-1:0]        dt;
        longint e, p, it, d, q, dt_l, sum;
        tgt   = word[31:0];
        meas  = word[63:32];
        stamp = word[95:64];
        res   = '0;
        if (!stamp_seen) begin
            stamp_seen = 1'b1;
            prev_stamp = stamp;
            return 1'b0;
        end
        e    = clamp32(longint'(tgt) - longint'(meas));
        dt   = stamp - prev_stamp;
        dt_l = longint'(dt);
        p    = (longint'(kp_gain) * e) >>> PdShift;
        integ_acc = add_sat64(integ_acc, e * dt_l);
        it   = integral_drive(ki_gain, integ_acc);
        d    = 0;
        if (dt != '0) begin
            q = (e - prev_err) / dt_l;
            d = (longint'(kd_gain) * q) >>> PdShift;
        end else begin
            o_zero_dt++;
        end
        sum = clamp32(p + it + d);
        prev_err   = e;
        prev_stamp = stamp;
        res.drive  = sum[31:0];
        res.err    = e[31:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_pid_result got;
        t_pid_result want;
        t_pid_result next_res;
        if (!i_rst_n) begin
            kp_gain    = KP_RESET;
            ki_gain    = KI_RESET;
            kd_gain    = KD_RESET;
            integ_acc  = 0;
            prev_err   = 0;
            prev_stamp = '0;
            stamp_seen = 1'b0;
            expected_drive_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_checked    = 0;
            o_zero_dt    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_KP: kp_gain = i_cfg_wdata;
                    CFG_KI: ki_gain = i_cfg_wdata;
                    CFG_KD: kd_gain = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Compare before pushing: a word taken at this edge cannot be answered yet.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_drive_q.size() == 0) begin
                    $error("unexpected result word: drive_value %0d, error_value %0d",
                           got.drive, got.err);
                    o_fail_count++;
                end else begin
                    want = expected_drive_q.pop_front();
                    o_checked++;
                    if (got.drive !== want.drive) begin
                        $error("drive_value mismatch: expected %0d, actual %0d",
                               want.drive, got.drive);
                        o_fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_value mismatch: expected %0d, actual %0d",
                               want.err, got.err);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (predict_drive(i_s_tdata, next_res)) expected_drive_q.push_back(next_res);
            end
            o_pending = expected_drive_q.size();
        end
    end

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam logic [CfgAddrW-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 600;
    localparam int CYCLE_LIMIT  = 2_500_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [InW-1:0]    s_tdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [OutW-1:0]   m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [DataW-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int zero_dt_steps;
    int words_sent = 0;
    int gain_sets = 1;
    int cycles_run = 0;
    bit gaps_on = 1'b0;
    bit hold_req = 1'b0;
    logic [DataW-1:0] stamp_now = '0;

    pid_position_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    pid_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_zero_dt    (zero_dt_steps)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles_run++;
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [DataW-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_sample(input logic [DataW-1:0] tgt, input logic [DataW-1:0] meas,
                               input logic [DataW-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {stamp, meas, tgt};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        words_sent++;
        stamp_now = stamp;
    endtask

    // The first word after reset yields nothing, so allow for its latency too.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [DataW-1:0] kp, input logic [DataW-1:0] ki,
                             input logic [DataW-1:0] kd, input int count,
                             input bit gaps, input bit hold);
        int mode;
        logic [DataW-1:0] tgt;
        logic [DataW-1:0] meas;
        logic [DataW-1:0] dt;
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_KP;
        cfg_wdata <= kp;
        @(negedge clk);
        cfg_addr  <= CFG_KI;
        cfg_wdata <= ki;
        @(negedge clk);
        cfg_addr  <= CFG_KD;
        cfg_wdata <= kd;
        @(negedge clk);
        // Index with no register behind it: must leave the gains alone.
        cfg_addr  <= CFG_UNUSED;
        cfg_wdata <= $urandom();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        gain_sets++;
        gaps_on = gaps;
        if (hold) hold_req = 1'b1;
        repeat (count) begin
            mode = $urandom_range(0, 99);
            tgt  = $urandom();
            meas = $urandom();
            dt   = $urandom_range(1, 50);
            if (mode < 60) begin
                meas = tgt + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end else if (mode < 72) begin
                dt = '0;
            end else if (mode < 87) begin
                dt = $urandom_range(0, 1000);
            end else if (mode < 94) begin
                tgt  = pick_extreme();
                meas = pick_extreme();
            end else begin
                // Long jumps and wrapped stamps, with small errors so the
                // integral does not pin at its limit.
                meas = tgt + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                dt   = $urandom();
            end
            send_sample(tgt, meas, stamp_now + dt);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial begin
        while (cycles_run < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycles_run, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;

        // Directed part, default gains.
        send_sample(32'd0, 32'd0, 32'd1000);
        send_sample(S32_MAX, S32_MIN, 32'd1001);
        send_sample(S32_MIN, S32_MAX, 32'd1003);
        send_sample(32'h0005_0000, 32'h0003_0000, 32'd1003);
        send_sample(32'hFFFF_FFFF, 32'd0, 32'd1004);
        send_sample(32'h0000_0064, 32'hFFFF_FF9C, 32'hFFFF_FFFF);
        send_sample(32'h0001_0000, 32'h0000_8000, 32'd0);
        send_sample(32'h0001_0000, 32'h0000_8000, 32'h0000_0010);
        // A dt of 2^32-1 with full-scale error drives the integral into both limits.
        for (int n = 0; n < 3; n++) send_sample(S32_MAX, S32_MIN, stamp_now - 32'd1);
        for (int n = 0; n < 4; n++) send_sample(S32_MIN, S32_MAX, stamp_now - 32'd1);
        send_sample(S32_MAX, S32_MIN, stamp_now - 32'd1);
        send_sample(32'd0, 32'd0, stamp_now + 32'd1);
        send_sample(32'd0, 32'd0, stamp_now);

        run_phase(S32_MIN, S32_MAX, S32_MIN, 150, 1'b1, 1'b0);
        run_phase(S32_MAX, S32_MIN, S32_MAX, 150, 1'b0, 1'b0);
        run_phase($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                  $urandom_range(0, 4000) - 32'd2000,
                  $urandom_range(0, 32'h0800_0000) - 32'h0400_0000, 400, 1'b1, 1'b1);
        run_phase($urandom(), $urandom(), $urandom(), 300, 1'b1, 1'b0);
        run_phase(32'd0, 32'd0, 32'd0, 100, 1'b0, 1'b0);
        run_phase(KP_RESET, KI_RESET, KD_RESET, 450, 1'b1, 1'b0);
        wait_idle();

        $display("Sent %0d samples under %0d gain settings, checked %0d drive words.",
                 words_sent, gain_sets, checked);
        $display("%0d of the checked words had a zero time step; %0d cycles in all.",
                 zero_dt_steps, cycles_run);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
